/* sv/mtc_pkg.sv */
// shared types, constants and calendar functions for the monthly trigger calculator
package mtc_pkg;

  localparam int AccW       = 28;
  localparam int YearW      = 11;
  localparam int IterW      = 5;
  localparam int LoopMax    = 24;
  localparam int YearBase   = 1900;
  localparam int MaxCentury = 10;
  localparam int DelayW     = 24;
  localparam int NowW       = 40;
  localparam int TimeW      = 41;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 6;
  localparam int InDataW    = 80;
  localparam int OutDataW   = 72;

  localparam logic signed [17:0] SecsPerDay  = 18'sd86400;
  localparam logic signed [17:0] SecsPerHour = 18'sd3600;
  localparam logic signed [17:0] SecsPerMin  = 18'sd60;
  localparam logic signed [17:0] SecsPerSec  = 18'sd1;

  localparam logic [3:0] MonthJan = 4'd0;
  localparam logic [3:0] MonthFeb = 4'd1;
  localparam logic [3:0] MonthApr = 4'd3;
  localparam logic [3:0] MonthJun = 4'd5;
  localparam logic [3:0] MonthSep = 4'd8;
  localparam logic [3:0] MonthNov = 4'd10;
  localparam logic [3:0] MonthDec = 4'd11;

  localparam logic [5:0] MaxFixedDay = 6'd31;

  localparam logic REQ_NEXT = 1'b0;
  localparam logic REQ_PREV = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_DAY    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOUR   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MINUTE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SECOND = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_SEC,
    ST_DECIDE,
    ST_FWD,
    ST_BACK,
    ST_LAST_FWD,
    ST_LAST_BACK,
    ST_FINISH
  } seq_state_t;

  typedef enum logic [1:0] {
    SCALE_DAY,
    SCALE_HOUR,
    SCALE_MIN,
    SCALE_SEC
  } scale_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    scale_t            scale;
    logic signed [6:0] coef;
  } alu_op_t;

  typedef struct packed {
    logic [5:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } trig_cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [9:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } req_t;

  // year is relative to the base year; base is a multiple of four
  function automatic logic leap_year(input logic signed [YearW-1:0] y);
    logic cent;
    logic quad;
    cent = 1'b0;
    quad = 1'b0;
    for (int k = 0; k <= MaxCentury; k++) begin
      if (y == YearW'(k * 100)) begin
        cent = 1'b1;
        if (((k * 100 + YearBase) % 400) == 0) quad = 1'b1;
      end
    end
    return ((y[1:0] == 2'b00) && !cent) || quad;
  endfunction

  function automatic logic [4:0] month_len(input logic signed [YearW-1:0] y,
                                           input logic [3:0] mo);
    logic [4:0] len;
    case (mo) inside
      MonthFeb:                             len = leap_year(y) ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default:                              len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* sv/monthly_trigger_time_calc.sv */
// top level of the monthly trigger time calculator
//
// Computes the next or previous occurrence of a monthly trigger point (day,
// hour, minute, second; day 32 and above means the last day of the month).
// Input stream in_*: one transfer carries the current Unix seconds and the
// broken-down date and time; in_tuser selects next (0) or previous (1).
// Output stream out_*: one transfer per request with the signed delay and
// the absolute trigger time, clamped at zero.
// Config channel cfg_*: index 0..3 writes day, hour, minute, second; it is
// always ready and should only be written while no request is in flight.
// Timing: one request at a time. A shared multiply-accumulate unit works out
// the day, hour, minute and second differences in turn; a decide step follows,
// then a step per month stepped (zero to two on real calendars), then a finish
// step. in_tready is low from the input transfer until the sequencer is back
// in idle after the finish step, so requests do not overlap.
// The result sits in an output register: a stalled receiver holds it, and
// the next request is accepted meanwhile; its result waits in the finish step.
// Reset (rst_n, synchronous) returns to idle, drops out_tvalid and sets the
// trigger point to day 1 at 00:00:00.
module monthly_trigger_time_calc import mtc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // now_seconds, year_since_1900, month_index, day_of_month, hour_now,
  // minute_now, second_now, zero pad
  input  logic [InDataW-1:0]  in_tdata,
  // req_type
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // delay_seconds, trigger_time, zero pad
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  trig_cfg_t              cfg_r, cfg_nxt;
  logic [NowW-1:0]        now_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [DelayW-1:0]      delay_r;
  logic [TimeW-1:0]       time_r;
  logic                   in_fire;
  logic                   out_free;
  logic                   fin;
  req_t                   item;
  alu_op_t                op;
  logic signed [AccW-1:0] acc;
  logic signed [TimeW:0]  sum;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign item.req_type = in_tuser;
  assign item.year     = in_tdata[49:40];
  assign item.month    = in_tdata[53:50];
  assign item.day      = in_tdata[58:54];
  assign item.hour     = in_tdata[63:59];
  assign item.minute   = in_tdata[69:64];
  assign item.second   = in_tdata[75:70];

  mtc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .item     (item),
    .cfg      (cfg_r),
    .acc      (acc),
    .out_free (out_free),
    .in_ready (in_tready),
    .finish   (fin),
    .op       (op)
  );

  mtc_alu u_alu (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DAY:    cfg_nxt.day    = cfg_data;
        CFG_HOUR:   cfg_nxt.hour   = cfg_data[4:0];
        CFG_MINUTE: cfg_nxt.minute = cfg_data;
        CFG_SECOND: cfg_nxt.second = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    sum = $signed({2'b00, now_r}) + (TimeW + 1)'(acc);
    out_valid_nxt = out_valid_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.day    <= 6'd1;
      cfg_r.hour   <= '0;
      cfg_r.minute <= '0;
      cfg_r.second <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r <= in_tdata[NowW-1:0];
    end
    if (fin) begin
      delay_r <= acc[DelayW-1:0];
      time_r  <= sum[TimeW] ? '0 : sum[TimeW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - DelayW - TimeW){1'b0}}, time_r, delay_r};

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input ready while a request is in flight");

  a_result_registered: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_tvalid)
    else $error("finished result not presented");

  a_no_take_while_finishing: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !in_tready)
    else $error("input accepted during finish step");

endmodule

/* sv/mtc_alu.sv */
// shared multiply-accumulate unit for the delay in seconds
module mtc_alu import mtc_pkg::*; (
  input  logic                   clk,
  input  alu_op_t                op,
  output logic signed [AccW-1:0] acc
);

  logic signed [AccW-1:0] acc_r;
  logic signed [AccW-1:0] acc_nxt;
  logic signed [AccW-1:0] base;
  logic signed [17:0]     scale_k;
  logic signed [24:0]     mul;

  always_comb begin
    unique case (op.scale)
      SCALE_DAY:  scale_k = SecsPerDay;
      SCALE_HOUR: scale_k = SecsPerHour;
      SCALE_MIN:  scale_k = SecsPerMin;
      SCALE_SEC:  scale_k = SecsPerSec;
      default:    scale_k = SecsPerSec;
    endcase
  end

  always_comb begin
    mul     = op.coef * scale_k;
    base    = op.clear ? '0 : acc_r;
    acc_nxt = base + AccW'(mul);
  end

  always_ff @(posedge clk) begin
    if (op.load) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* sv/mtc_seq.sv */
// sequencer: day/time difference steps and month walk
module mtc_seq import mtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  req_t                   item,
  input  trig_cfg_t              cfg,
  input  logic signed [AccW-1:0] acc,
  input  logic                   out_free,
  output logic                   in_ready,
  output logic                   finish,
  output alu_op_t                op
);

  seq_state_t state_r, state_nxt;

  logic                    prev_r, prev_nxt;
  logic signed [YearW-1:0] year_r, year_nxt;
  logic [3:0]              mon_r, mon_nxt;
  logic [4:0]              days_r, days_nxt;
  logic [4:0]              day_r, day_nxt;
  logic [4:0]              hour_r, hour_nxt;
  logic [5:0]              min_r, min_nxt;
  logic [5:0]              sec_r, sec_nxt;
  logic [IterW-1:0]        iter_r, iter_nxt;

  logic                    last_day;
  logic [5:0]              tsel;
  logic [3:0]              mon_in;
  logic signed [YearW-1:0] year_in;
  logic [3:0]              fwd_mon, bwd_mon;
  logic signed [YearW-1:0] fwd_year, bwd_year;
  logic [4:0]              fwd_len, bwd_len;
  logic                    acc_nonpos;
  logic                    iter_end;

  always_comb begin
    last_day   = cfg.day > MaxFixedDay;
    tsel       = last_day ? {1'b0, days_r} : cfg.day;
    mon_in     = (item.month > MonthDec) ? MonthDec : item.month;
    year_in    = {1'b0, item.year};
    fwd_mon    = (mon_r == MonthDec) ? MonthJan : mon_r + 4'd1;
    fwd_year   = (mon_r == MonthDec) ? year_r + YearW'(1) : year_r;
    bwd_mon    = (mon_r == MonthJan) ? MonthDec : mon_r - 4'd1;
    bwd_year   = (mon_r == MonthJan) ? year_r - YearW'(1) : year_r;
    fwd_len    = month_len(fwd_year, fwd_mon);
    bwd_len    = month_len(bwd_year, bwd_mon);
    acc_nonpos = acc[AccW-1] || (acc == '0);
    iter_end   = iter_r == IterW'(LoopMax - 1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_DAY;
      ST_DAY:    state_nxt = ST_HOUR;
      ST_HOUR:   state_nxt = ST_MIN;
      ST_MIN:    state_nxt = ST_SEC;
      ST_SEC:    state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!last_day) begin
          if (prev_r == REQ_NEXT) begin
            state_nxt = (acc_nonpos || ({1'b0, days_r} < cfg.day)) ? ST_FWD : ST_FINISH;
          end else begin
            state_nxt = acc_nonpos ? ST_FINISH : ST_BACK;
          end
        end else begin
          if (prev_r == REQ_NEXT) begin
            state_nxt = acc_nonpos ? ST_LAST_FWD : ST_FINISH;
          end else begin
            state_nxt = acc_nonpos ? ST_FINISH : ST_LAST_BACK;
          end
        end
      end
      ST_FWD: begin
        if (({1'b0, fwd_len} >= cfg.day) || iter_end) state_nxt = ST_FINISH;
      end
      ST_BACK: begin
        if (({1'b0, bwd_len} >= cfg.day) || iter_end) state_nxt = ST_FINISH;
      end
      ST_LAST_FWD:  state_nxt = ST_FINISH;
      ST_LAST_BACK: state_nxt = ST_FINISH;
      ST_FINISH:    if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = state_r == ST_IDLE;
    finish   = (state_r == ST_FINISH) && out_free;
    op.load  = 1'b1;
    op.clear = 1'b0;
    op.scale = SCALE_DAY;
    op.coef  = '0;
    unique case (state_r)
      ST_DAY: begin
        op.clear = 1'b1;
        op.coef  = $signed({1'b0, tsel}) - $signed({2'b00, day_r});
      end
      ST_HOUR: begin
        op.scale = SCALE_HOUR;
        op.coef  = $signed({2'b00, cfg.hour}) - $signed({2'b00, hour_r});
      end
      ST_MIN: begin
        op.scale = SCALE_MIN;
        op.coef  = $signed({1'b0, cfg.minute}) - $signed({1'b0, min_r});
      end
      ST_SEC: begin
        op.scale = SCALE_SEC;
        op.coef  = $signed({1'b0, cfg.second}) - $signed({1'b0, sec_r});
      end
      ST_FWD:       op.coef = $signed({2'b00, days_r});
      ST_LAST_FWD:  op.coef = $signed({2'b00, fwd_len});
      ST_BACK:      op.coef = -$signed({2'b00, bwd_len});
      ST_LAST_BACK: op.coef = -$signed({2'b00, days_r});
      ST_IDLE, ST_DECIDE, ST_FINISH: op.load = 1'b0;
      default:      op.load = 1'b0;
    endcase
  end

  // item and calendar registers
  always_comb begin
    prev_nxt = prev_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    days_nxt = days_r;
    day_nxt  = day_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    iter_nxt = iter_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          prev_nxt = item.req_type;
          year_nxt = year_in;
          mon_nxt  = mon_in;
          days_nxt = month_len(year_in, mon_in);
          day_nxt  = item.day;
          hour_nxt = item.hour;
          min_nxt  = item.minute;
          sec_nxt  = item.second;
        end
      end
      ST_DECIDE: iter_nxt = '0;
      ST_FWD: begin
        year_nxt = fwd_year;
        mon_nxt  = fwd_mon;
        days_nxt = fwd_len;
        iter_nxt = iter_r + IterW'(1);
      end
      ST_BACK: begin
        year_nxt = bwd_year;
        mon_nxt  = bwd_mon;
        days_nxt = bwd_len;
        iter_nxt = iter_r + IterW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    days_r <= days_nxt;
    day_r  <= day_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    iter_r <= iter_nxt;
  end

endmodule

/* bench/testbench.sv */
// self-checking bench for the monthly trigger time calculator
`timescale 1ns / 100ps

module testbench;
  import mtc_pkg::*;

  localparam int NumPhases = 8;
  localparam int PhaseItems = 191;
  localparam int SettleCycles = 20;
  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 3000;
  localparam longint DaySecs = 86400;
  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic        req_type;
    logic [39:0] now;
    logic [9:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } alarm_req_t;

  typedef struct {
    logic signed [DelayW-1:0] delay;
    logic [TimeW-1:0]         when;
  } alarm_res_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  alarm_req_t pending_reqs[$];
  alarm_res_t due_results[$];
  alarm_req_t on_wire;
  trig_cfg_t  trig_shadow = '{day: 6'd1, hour: 5'd0, minute: 6'd0, second: 6'd0};

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int queued = 0;
  int accepted = 0;
  int results_seen = 0;
  int errors = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit hold_off_armed = 1'b0;

  monthly_trigger_time_calc uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint month_days_of(longint y_rel, longint mo);
    longint yr;
    yr = y_rel + 1900;
    if (mo == 1) begin
      return (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)) ? 29 : 28;
    end
    return longint'(MonthDays[mo]);
  endfunction

  function automatic longint gap_in_month(longint tday, alarm_req_t r);
    longint d, h, m, s;
    d = longint'(r.day);
    h = longint'(r.hour);
    m = longint'(r.minute);
    s = longint'(r.second);
    return (tday - d) * DaySecs + (longint'(trig_shadow.hour) - h) * 3600
         + (longint'(trig_shadow.minute) - m) * 60 + (longint'(trig_shadow.second) - s);
  endfunction

  function automatic alarm_res_t forecast_alarm(alarm_req_t r);
    alarm_res_t res;
    longint delay, y, mo, days, tday, t;
    y = longint'(r.year);
    mo = longint'(r.month);
    if (mo > 11) mo = 11;
    days = month_days_of(y, mo);
    tday = longint'(trig_shadow.day);
    if (tday <= 31) begin
      delay = gap_in_month(tday, r);
      if (r.req_type == REQ_NEXT) begin
        if (delay <= 0 || days < tday) begin
          for (int i = 0; i < 24; i++) begin
            delay += days * DaySecs;
            mo++;
            if (mo > 11) begin
              mo = 0;
              y++;
            end
            days = month_days_of(y, mo);
            if (days >= tday) break;
          end
        end
      end else if (delay > 0) begin
        for (int i = 0; i < 24; i++) begin
          mo--;
          if (mo < 0) begin
            mo = 11;
            y--;
          end
          days = month_days_of(y, mo);
          delay -= days * DaySecs;
          if (days >= tday) break;
        end
      end
    end else begin
      // last day of the month
      delay = gap_in_month(days, r);
      if (r.req_type == REQ_NEXT) begin
        if (delay <= 0) begin
          if (mo < 11) delay += month_days_of(y, mo + 1) * DaySecs;
          else delay += month_days_of(y + 1, 0) * DaySecs;
        end
      end else if (delay > 0) begin
        delay -= days * DaySecs;
      end
    end
    t = longint'(r.now) + delay;
    if (t < 0) t = 0;
    res.delay = delay[DelayW-1:0];
    res.when = t[TimeW-1:0];
    return res;
  endfunction

  function automatic alarm_req_t make_req(logic rt, logic [39:0] now, int y, int mo,
                                          int d, int h, int mi, int s);
    alarm_req_t r;
    r.req_type = rt;
    r.now = now;
    r.year = y[9:0];
    r.month = mo[3:0];
    r.day = d[4:0];
    r.hour = h[4:0];
    r.minute = mi[5:0];
    r.second = s[5:0];
    return r;
  endfunction

  function automatic alarm_req_t random_req();
    alarm_req_t r;
    int pick, mo, mlen;
    r.req_type = $urandom_range(1) ? REQ_PREV : REQ_NEXT;
    pick = $urandom_range(99);
    if (pick < 20) r.year = 10'(100 * $urandom_range(10));
    else if (pick < 35) r.year = 10'(4 * $urandom_range(255));
    else r.year = 10'($urandom_range(1023));
    r.month = ($urandom_range(99) < 6) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
    mo = (r.month > 11) ? 11 : int'(r.month);
    mlen = int'(month_days_of(longint'(r.year), longint'(mo)));
    pick = $urandom_range(99);
    if (pick < 6) r.day = 5'($urandom_range(31));
    else if (pick < 25) r.day = 5'($urandom_range(mlen, mlen - 1));
    else r.day = 5'($urandom_range(mlen, 1));
    r.hour = ($urandom_range(99) < 5) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
    r.minute = ($urandom_range(99) < 5) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
    r.second = ($urandom_range(99) < 5) ? 6'($urandom_range(63)) : 6'($urandom_range(60));
    // land right on the trigger point now and then
    if ($urandom_range(99) < 12) begin
      if (trig_shadow.day >= 1 && trig_shadow.day <= mlen) r.day = 5'(trig_shadow.day);
      else r.day = 5'(mlen);
      r.hour = trig_shadow.hour;
      r.minute = trig_shadow.minute;
      r.second = trig_shadow.second;
    end
    pick = $urandom_range(99);
    if (pick < 20) r.now = 40'($urandom_range(6000000));
    else if (pick < 23) r.now = '1;
    else r.now = 40'({$urandom, $urandom});
    return r;
  endfunction

  function automatic void enqueue(alarm_req_t r);
    pending_reqs.push_back(r);
    queued++;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_DAY:    trig_shadow.day = val;
      CFG_HOUR:   trig_shadow.hour = val[4:0];
      CFG_MINUTE: trig_shadow.minute = val;
      CFG_SECOND: trig_shadow.second = val;
      default:    ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_trigger(int d, int h, int m, int s);
    write_reg(CFG_DAY, d[5:0]);
    write_reg(CFG_HOUR, h[5:0]);
    write_reg(CFG_MINUTE, m[5:0]);
    write_reg(CFG_SECOND, s[5:0]);
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: set_trigger(31, 23, 59, 59);
        2: set_trigger(32, 12, 30, 0);
        3: set_trigger(29, 1, 2, 3);
        4: set_trigger(30, 6, 15, 45);
        5: set_trigger(63, 63, 63, 63);
        6: set_trigger(0, 0, 0, 0);
        7: set_trigger($urandom_range(32, 1), $urandom_range(23), $urandom_range(59),
                       $urandom_range(59));
        default: ;
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
      endcase
      if (ph == 0) begin
        // reset trigger point: day 1 at midnight
        enqueue(make_req(REQ_NEXT, 40'd1700000000, 0, 0, 1, 0, 0, 0));
        enqueue(make_req(REQ_PREV, 40'd1700000000, 0, 0, 1, 0, 0, 0));
        enqueue(make_req(REQ_PREV, 40'd1000, 0, 0, 0, 0, 0, 0));
        enqueue(make_req(REQ_NEXT, 40'hFF_FFFF_FFFF, 1023, 11, 31, 23, 59, 60));
        enqueue(make_req(REQ_PREV, 40'hFF_FFFF_FFFF, 1023, 11, 31, 23, 59, 59));
        enqueue(make_req(REQ_PREV, 40'd0, 70, 5, 15, 12, 0, 0));
        enqueue(make_req(REQ_NEXT, 40'd0, 70, 5, 15, 12, 0, 0));
        enqueue(make_req(REQ_NEXT, 40'd123456789, 99, 12, 10, 1, 1, 1));
        enqueue(make_req(REQ_PREV, 40'd123456789, 99, 15, 31, 0, 0, 0));
        enqueue(make_req(REQ_NEXT, 40'd5000000, 124, 1, 29, 31, 63, 63));
        enqueue(make_req(REQ_PREV, 40'd5000000, 124, 1, 0, 31, 63, 63));
        enqueue(make_req(REQ_NEXT, 40'd86400, 512, 6, 31, 0, 0, 60));
        enqueue(make_req(REQ_PREV, 40'd86400, 512, 6, 1, 0, 0, 1));
        enqueue(make_req(REQ_NEXT, 40'h55_5555_5555, 341, 10, 21, 10, 42, 21));
        enqueue(make_req(REQ_PREV, 40'hAA_AAAA_AAAA, 682, 5, 10, 21, 21, 42));
        enqueue(make_req(REQ_NEXT, 40'd2000000000, 0, 2, 1, 0, 0, 0));
      end else if (ph == 1) begin
        // day 31 across short months and leap rules
        enqueue(make_req(REQ_PREV, 40'd4000000000, 0, 2, 1, 0, 0, 0));
        enqueue(make_req(REQ_PREV, 40'd4000000000, 100, 2, 1, 0, 0, 0));
        enqueue(make_req(REQ_PREV, 40'd4000000000, 200, 2, 1, 0, 0, 0));
        enqueue(make_req(REQ_PREV, 40'd4000000000, 124, 2, 1, 0, 0, 0));
        enqueue(make_req(REQ_PREV, 40'd4000000000, 123, 2, 1, 0, 0, 0));
        enqueue(make_req(REQ_NEXT, 40'd4000000000, 100, 0, 31, 23, 59, 59));
        enqueue(make_req(REQ_NEXT, 40'd4000000000, 0, 0, 31, 23, 59, 59));
      end
      repeat (PhaseItems) enqueue(random_req());
      if (ph == 4) hold_off_armed = 1'b1;
      while (accepted != queued || due_results.size() != 0) @(posedge clk);
      repeat (SettleCycles) @(posedge clk);
    end
    $display("checked %0d of %0d requests under %0d trigger settings,", results_seen, queued,
             NumPhases);
    $display("with free-running, sender-idle, receiver-stall and mixed flow control");
    if (errors == 0) begin
      $display("monthly_trigger_time_calc regression: pass");
    end else begin
      $display("monthly_trigger_time_calc regression: fail");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(forecast_alarm(on_wire));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'b0, on_wire.second, on_wire.minute, on_wire.hour, on_wire.day,
                       on_wire.month, on_wire.year, on_wire.now};
          in_tuser <= on_wire.req_type;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    alarm_res_t exp_res;
    logic signed [DelayW-1:0] got_delay;
    logic [TimeW-1:0] got_when;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_delay = out_tdata[DelayW-1:0];
        got_when = out_tdata[DelayW +: TimeW];
        results_seen++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result delay %0d time %0d", $time, got_delay, got_when);
          errors++;
        end else begin
          exp_res = due_results.pop_front();
          if (got_delay !== exp_res.delay) begin
            $display("%0t: delay mismatch, expected %0d, actual %0d", $time, exp_res.delay,
                     got_delay);
            errors++;
          end
          if (got_when !== exp_res.when) begin
            $display("%0t: trigger time mismatch, expected %0d, actual %0d", $time,
                     exp_res.when, got_when);
            errors++;
          end
        end
        if (hold_off_armed) begin
          hold_left = HoldOffCycles;
          hold_off_armed = 1'b0;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: timeout, %0d results still due", $time, due_results.size());
        $display("monthly_trigger_time_calc regression: fail");
        $finish;
      end
    end
  end

endmodule
